FILE: src/huffman_code_bit_packer_macros.svh
// Assertion macros shared by the packer checker.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// checked only outside reset
`define HCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HCBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/hcbp_pkg.sv
// Shared constants, codes and types of the code bit packer.
package hcbp_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int MAX_CODE_LEN  = 24;
  localparam int QUEUE_DEPTH   = 4;

  localparam int ACT_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 24;
  localparam int LEN_W  = 5;
  localparam int BYTE_W = 8;
  localparam int WIN_W  = 40;
  localparam int TOT_W  = 6;
  localparam int NB_W   = 3;
  localparam int PEND_W = 3;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } job_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_t;

  // saturate the length, then clear code bits at or above it
  function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if ({1'b0, len} > (LEN_W+1)'(MAX_CODE_LEN)) begin
      res = LEN_W'(MAX_CODE_LEN);
    end
    return res;
  endfunction

  function automatic logic [CODE_W-1:0] mask_code(logic [CODE_W-1:0] code,
                                                  logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] res;
    res = code;
    if ({1'b0, len} < (LEN_W+1)'(CODE_W)) begin
      res = code & ((CODE_W'(1) << len) - CODE_W'(1));
    end
    return res;
  endfunction

endpackage

FILE: src/huffman_code_bit_packer.sv
// Top level of the code bit packer: front end, job queue, back end, byte queue.
//
// Input queue side: drive action/symbol/code fields with push; a request is
// taken at a clock edge with push high and full low. A load writes one code
// table entry, an encode appends the symbol's code, a flush pads and sends
// the pending partial byte. Loads and ignored requests give no bytes.
// Output queue side: packed_byte_o/last_o show the oldest byte while empty is
// low; pop takes it. last_o marks the final byte of one request.
// On its way to the output a byte passes the table read, the job queue, the
// shift window and the byte queue.
// Throughput: one request per cycle while each makes at most one byte and the
// byte queue has room; the byte shifter sends one byte per cycle, so a request
// making more than one byte holds it until its last byte is sent.
// Reset clears the pending bits and both queues; table entries are undefined
// until loaded and must be loaded before use.
// A stalled receiver fills the four-entry byte queue, then the job queue,
// and then full rises.
module huffman_code_bit_packer #(
  parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE,
  parameter int QUEUE_DEPTH   = hcbp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [hcbp_pkg::ACT_W-1:0]  action_i,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0] code_bits_i,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [hcbp_pkg::BYTE_W-1:0] packed_byte_o,
  output logic                        last_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH+1);
  localparam int JobW = $bits(hcbp_pkg::job_t);
  localparam int OutW = $bits(hcbp_pkg::out_t);

  logic            job_valid, job_pop, jq_empty, jq_full, ob_push, ob_full;
  logic [CntW-1:0] jq_count, ob_count;
  hcbp_pkg::job_t  job_in, job_out;
  hcbp_pkg::out_t  ob_in, ob_out;
  logic [JobW-1:0] jq_rdata;
  logic [OutW-1:0] ob_rdata;

  hcbp_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .symbol_i     (symbol_i),
    .code_bits_i  (code_bits_i),
    .code_length_i(code_length_i),
    .q_count_i    (jq_count),
    .job_valid_o  (job_valid),
    .job_o        (job_in)
  );

  hcbp_fifo #(
    .WIDTH(JobW),
    .DEPTH(QUEUE_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .wdata_i(job_in),
    .pop_i  (job_pop),
    .rdata_o(jq_rdata),
    .empty_o(jq_empty),
    .full_o (jq_full),
    .count_o(jq_count)
  );

  assign job_out = hcbp_pkg::job_t'(jq_rdata);

  hcbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!jq_empty && !jq_full || !jq_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .out_full_i (ob_full),
    .out_push_o (ob_push),
    .out_o      (ob_in)
  );

  hcbp_fifo #(
    .WIDTH(OutW),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ob_push),
    .wdata_i(ob_in),
    .pop_i  (pop),
    .rdata_o(ob_rdata),
    .empty_o(empty),
    .full_o (ob_full),
    .count_o(ob_count)
  );

  assign ob_out        = hcbp_pkg::out_t'(ob_rdata);
  assign packed_byte_o = ob_out.data;
  assign last_o        = ob_out.last && (ob_count != '0);

endmodule

FILE: src/hcbp_fifo.sv
// Small register queue with occupancy count.
module hcbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH-1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH-1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign count_o = cnt_q;

endmodule

FILE: src/hcbp_front.sv
// Front end: takes requests, owns the code table, issues encode and flush jobs.
module hcbp_front #(
  parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE,
  parameter int QUEUE_DEPTH   = hcbp_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic [hcbp_pkg::ACT_W-1:0]         action_i,
  input  logic [hcbp_pkg::SYM_W-1:0]         symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0]        code_bits_i,
  input  logic [hcbp_pkg::LEN_W-1:0]         code_length_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count_i,
  output logic                               job_valid_o,
  output hcbp_pkg::job_t                     job_o
);

  localparam int IdxW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int CntW   = $clog2(QUEUE_DEPTH+1);
  localparam int EntryW = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

  logic [EntryW-1:0] code_table_q [ALPHABET_SIZE];
  logic [EntryW-1:0] rd_data_q;
  logic [EntryW-1:0] wr_data;
  logic [IdxW-1:0]   idx;
  logic              accept, in_range, wr_en, rd_en, fl_en;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_flush_q;
  logic [hcbp_pkg::LEN_W-1:0] len_sat;

  assign accept   = push_i && !full_o;
  assign in_range = {1'b0, symbol_i} < (hcbp_pkg::SYM_W+1)'(ALPHABET_SIZE);
  assign idx      = symbol_i[IdxW-1:0];
  assign wr_en    = accept && in_range && (action_i == hcbp_pkg::ACT_LOAD);
  assign rd_en    = accept && in_range && (action_i == hcbp_pkg::ACT_ENCODE);
  assign fl_en    = accept && (action_i == hcbp_pkg::ACT_FLUSH);
  assign len_sat  = hcbp_pkg::sat_len(code_length_i);
  assign wr_data  = {len_sat, hcbp_pkg::mask_code(code_bits_i, len_sat)};
  assign s1_valid_d = rd_en || fl_en;

  // one job may still be on its way into the queue
  assign full_o = ({1'b0, q_count_i} + (CntW+1)'(s1_valid_q)) >= (CntW+1)'(QUEUE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      code_table_q[idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= code_table_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_d) begin
      s1_flush_q <= fl_en;
    end
  end

  assign job_valid_o = s1_valid_q;
  always_comb begin
    job_o.flush = s1_flush_q;
    job_o.len   = s1_flush_q ? '0 : rd_data_q[EntryW-1:hcbp_pkg::CODE_W];
    job_o.code  = s1_flush_q ? '0 : rd_data_q[hcbp_pkg::CODE_W-1:0];
  end

endmodule

FILE: src/hcbp_back.sv
// Back end: appends codes to the pending bits and sends out completed bytes.
module hcbp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  hcbp_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           out_full_i,
  output logic           out_push_o,
  output hcbp_pkg::out_t out_o
);

  localparam int WinW  = hcbp_pkg::WIN_W;
  localparam int ByteW = hcbp_pkg::BYTE_W;
  localparam int TotW  = hcbp_pkg::TOT_W;
  localparam int NbW   = hcbp_pkg::NB_W;
  localparam int PendW = hcbp_pkg::PEND_W;
  localparam int LenW  = hcbp_pkg::LEN_W;

  logic [ByteW-1:0] part_q, part_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [WinW-1:0]  win_q, win_d, window;
  logic [NbW-1:0]   cnt_q, cnt_d, nbytes;
  logic             busy_q, busy_d;
  logic             emit, take;
  logic [LenW-1:0]  len_eff;
  logic [TotW-1:0]  total, shamt;

  assign emit = busy_q && !out_full_i;
  assign take = job_valid_i && (!busy_q || (emit && cnt_q == NbW'(1)));

  // a flush pads the pending bits up to a byte boundary with zeros
  always_comb begin
    len_eff = job_i.len;
    if (job_i.flush) begin
      len_eff = (pend_q == '0) ? '0 : LenW'(ByteW) - LenW'(pend_q);
    end
  end

  assign total  = TotW'(pend_q) + TotW'(len_eff);
  assign shamt  = TotW'(WinW) - total;
  assign window = {part_q, {(WinW-ByteW){1'b0}}} | (WinW'(job_i.code) << shamt);
  assign nbytes = total[TotW-1:PendW];

  always_comb begin
    part_d = part_q;
    pend_d = pend_q;
    win_d  = win_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (take) begin
      part_d = ByteW'(window >> (TotW'(WinW - ByteW) - {nbytes, {PendW{1'b0}}}));
      pend_d = total[PendW-1:0];
      win_d  = window;
      cnt_d  = nbytes;
      busy_d = (nbytes != '0);
    end else if (emit) begin
      win_d  = win_q << ByteW;
      cnt_d  = cnt_q - NbW'(1);
      busy_d = (cnt_q != NbW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      part_q <= part_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign job_pop_o  = take;
  assign out_push_o = emit;
  assign out_o.data = win_q[WinW-1 -: ByteW];
  assign out_o.last = (cnt_q == NbW'(1));

endmodule

FILE: src/hcbp_checker.sv
// Port-level checks of the code bit packer, bound to the top level.
`include "huffman_code_bit_packer_macros.svh"

module hcbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [hcbp_pkg::BYTE_W-1:0] packed_byte_o,
  input logic                        last_o
);

  `HCBP_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> empty, "output queue not empty after reset")
  `HCBP_ASSERT_ALWAYS(a_rst_full, !rst_ni |=> !full, "input side full after reset")
  `HCBP_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(packed_byte_o) && $stable(last_o), "waiting byte changed")
  `HCBP_ASSERT(a_more, !empty && pop && !last_o |=> !empty, "byte of a request missing after a non-final byte")

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

FILE: tb/huffman_code_bit_packer_test.sv
// Self-checking testbench of the code bit packer: directed table, then random requests.
module huffman_code_bit_packer_test;

  localparam logic [hcbp_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 145;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_ROWS = 25;

  typedef struct packed {
    logic [hcbp_pkg::BYTE_W-1:0] data;
    logic                        last;
  } byte_exp_t;

  typedef struct packed {
    logic [hcbp_pkg::ACT_W-1:0]  act;
    logic [hcbp_pkg::SYM_W-1:0]  sym;
    logic [hcbp_pkg::CODE_W-1:0] code;
    logic [hcbp_pkg::LEN_W-1:0]  len;
    logic                        typed;
    logic [1:0]                  n;
    logic [23:0]                 bytes;
  } dir_row_t;

  // typed rows: n bytes, first byte in bits 23:16
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{hcbp_pkg::ACT_LOAD,   8'h00, 24'h0000FF, 5'd8,  1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h00, 24'h000000, 5'd0,  1'b1, 2'd1, 24'hFF0000},
    '{hcbp_pkg::ACT_LOAD,   8'hFF, 24'hFFFFFF, 5'd24, 1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'hFF, 24'h000000, 5'd0,  1'b1, 2'd3, 24'hFFFFFF},
    '{hcbp_pkg::ACT_LOAD,   8'h01, 24'h000001, 5'd1,  1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h01, 24'h000000, 5'd0,  1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  1'b1, 2'd1, 24'h800000},
    '{hcbp_pkg::ACT_FLUSH,  8'hFF, 24'hFFFFFF, 5'd31, 1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_LOAD,   8'h02, 24'hFFFFFF, 5'd31, 1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_LOAD,   8'h03, 24'hFFFFFF, 5'd3,  1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h03, 24'h000000, 5'd0,  1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h02, 24'h000000, 5'd0,  1'b1, 2'd3, 24'hFFFFFF},
    '{hcbp_pkg::ACT_LOAD,   8'h04, 24'hABCDEF, 5'd0,  1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h04, 24'h000000, 5'd0,  1'b1, 2'd0, 24'h000000},
    '{ACT_UNUSED,           8'h01, 24'hFFFFFF, 5'd31, 1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_LOAD,   8'h05, 24'h000000, 5'd24, 1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h05, 24'h000000, 5'd0,  1'b0, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  1'b0, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_LOAD,   8'h06, 24'hAAAAAA, 5'd24, 1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h06, 24'h000000, 5'd0,  1'b0, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_LOAD,   8'h07, 24'hFD5555, 5'd23, 1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h07, 24'h000000, 5'd0,  1'b0, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_LOAD,   8'h08, 24'h000005, 5'd3,  1'b1, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h08, 24'h000000, 5'd0,  1'b0, 2'd0, 24'h000000},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  1'b0, 2'd0, 24'h000000}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        push;
  logic                        full;
  logic [hcbp_pkg::ACT_W-1:0]  action_i;
  logic [hcbp_pkg::SYM_W-1:0]  symbol_i;
  logic [hcbp_pkg::CODE_W-1:0] code_bits_i;
  logic [hcbp_pkg::LEN_W-1:0]  code_length_i;
  logic                        empty;
  logic                        pop;
  logic [hcbp_pkg::BYTE_W-1:0] packed_byte_o;
  logic                        last_o;

  huffman_code_bit_packer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .empty         (empty),
    .pop           (pop),
    .packed_byte_o (packed_byte_o),
    .last_o        (last_o)
  );

  // predictor state
  logic [hcbp_pkg::CODE_W-1:0] tbl_code [hcbp_pkg::ALPHABET_SIZE];
  logic [hcbp_pkg::LEN_W-1:0]  tbl_len  [hcbp_pkg::ALPHABET_SIZE];
  bit                          tbl_set  [hcbp_pkg::ALPHABET_SIZE];
  logic [hcbp_pkg::SYM_W-1:0]  loaded_syms [$];
  logic [7:0]                  part_byte;
  logic [2:0]                  part_bits;

  byte_exp_t new_bytes [$];
  byte_exp_t expected_bytes [$];

  int tx_idle;
  int rx_idle;
  int err_cnt;
  int cycles;
  int n_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[huffman_code_bit_packer] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input byte_exp_t exp_b, input byte_exp_t got_b);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s: expected byte %02h last %0d, got byte %02h last %0d",
               what, exp_b.data, exp_b.last, got_b.data, got_b.last);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      pop = ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    byte_exp_t got_b;
    byte_exp_t exp_b;
    if (rst_ni && pop && !empty) begin
      got_b.data = packed_byte_o;
      got_b.last = last_o;
      if (expected_bytes.size() == 0) begin
        report("unexpected byte", '0, got_b);
      end else begin
        exp_b = expected_bytes.pop_front();
        if (got_b !== exp_b) begin
          report("byte mismatch", exp_b, got_b);
        end
      end
    end
  end

  // appends a request's effect to the predictor, new bytes land in new_bytes
  task automatic pack_code(input logic [hcbp_pkg::ACT_W-1:0] act,
                           input logic [hcbp_pkg::SYM_W-1:0] sym,
                           input logic [hcbp_pkg::CODE_W-1:0] code,
                           input logic [hcbp_pkg::LEN_W-1:0] len);
    logic [hcbp_pkg::LEN_W-1:0] l;
    logic [39:0]                win;
    logic [63:0]                masked;
    int                         total;
    int                         nb;
    int                         sh;
    new_bytes.delete();
    case (act)
      hcbp_pkg::ACT_LOAD: begin
        l = (len > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) ?
            hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : len;
        masked = 64'(code) & ((64'd1 << l) - 64'd1);
        tbl_code[sym] = masked[hcbp_pkg::CODE_W-1:0];
        tbl_len[sym] = l;
        if (!tbl_set[sym]) begin
          tbl_set[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      hcbp_pkg::ACT_ENCODE: begin
        l = tbl_len[sym];
        sh = 40 - int'(part_bits) - int'(l);
        win = {part_byte, 32'd0} | (40'(tbl_code[sym]) << sh);
        total = int'(part_bits) + int'(l);
        nb = total / 8;
        for (int k = 0; k < nb; k++) begin
          new_bytes.push_back('{win[39-8*k -: 8], (k == nb - 1)});
        end
        part_byte = win[39-8*nb -: 8];
        part_bits = 3'(total % 8);
      end
      hcbp_pkg::ACT_FLUSH: begin
        if (part_bits != 0) begin
          new_bytes.push_back('{part_byte, 1'b1});
        end
        part_byte = '0;
        part_bits = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_req(input logic [hcbp_pkg::ACT_W-1:0] act,
                          input logic [hcbp_pkg::SYM_W-1:0] sym,
                          input logic [hcbp_pkg::CODE_W-1:0] code,
                          input logic [hcbp_pkg::LEN_W-1:0] len);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    action_i = act;
    symbol_i = sym;
    code_bits_i = code;
    code_length_i = len;
    do @(posedge clk_i); while (full);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic rand_request();
    logic [hcbp_pkg::ACT_W-1:0]  act;
    logic [hcbp_pkg::SYM_W-1:0]  sym;
    logic [hcbp_pkg::CODE_W-1:0] code;
    logic [hcbp_pkg::LEN_W-1:0]  len;
    int r;
    r = $urandom_range(99);
    sym = hcbp_pkg::SYM_W'($urandom);
    code = hcbp_pkg::CODE_W'($urandom);
    len = hcbp_pkg::LEN_W'($urandom);
    if (r < 20 || loaded_syms.size() == 0) begin
      act = hcbp_pkg::ACT_LOAD;
      r = $urandom_range(99);
      if (r < 80) len = hcbp_pkg::LEN_W'($urandom_range(1, 9));
      else if (r < 95) len = hcbp_pkg::LEN_W'($urandom_range(10, 24));
      else len = hcbp_pkg::LEN_W'($urandom_range(0, 31));
    end else if (r < 85) begin
      act = hcbp_pkg::ACT_ENCODE;
      sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
    end else if (r < 96) begin
      act = hcbp_pkg::ACT_FLUSH;
    end else begin
      act = ACT_UNUSED;
    end
    send_req(act, sym, code, len);
    pack_code(act, sym, code, len);
    foreach (new_bytes[i]) expected_bytes.push_back(new_bytes[i]);
    n_sent++;
  endtask

  initial begin
    dir_row_t row;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    action_i = '0;
    symbol_i = '0;
    code_bits_i = '0;
    code_length_i = '0;
    tx_idle = 21;
    rx_idle = 49;
    err_cnt = 0;
    cycles = 0;
    n_sent = 0;
    part_byte = '0;
    part_bits = '0;
    foreach (tbl_set[i]) begin
      tbl_set[i] = 1'b0;
      tbl_code[i] = '0;
      tbl_len[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      row = DIR_ROWS[i];
      send_req(row.act, row.sym, row.code, row.len);
      pack_code(row.act, row.sym, row.code, row.len);
      if (row.typed) begin
        for (int k = 0; k < int'(row.n); k++) begin
          expected_bytes.push_back('{row.bytes[23-8*k -: 8], (k == int'(row.n) - 1)});
        end
      end else begin
        foreach (new_bytes[j]) expected_bytes.push_back(new_bytes[j]);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle = 21; rx_idle = 49; end
        1: begin tx_idle = 49; rx_idle = 21; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      while (n_sent < (ph + 1) * RAND_ITEMS / 3) rand_request();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && expected_bytes.size() == 0) begin
      $display("[huffman_code_bit_packer] OK");
    end else begin
      $display("[huffman_code_bit_packer] ERROR");
    end
    $finish;
  end

endmodule

FILE: huffman_code_bit_packer.f
+incdir+src
src/hcbp_pkg.sv
src/hcbp_fifo.sv
src/hcbp_front.sv
src/hcbp_back.sv
src/huffman_code_bit_packer.sv
src/hcbp_checker.sv
tb/huffman_code_bit_packer_test.sv
